>>> sv/trld_pkg.sv
// ----------------------------------------------------------------------------
// trld_pkg
// shared constants, command codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trld_pkg;

   localparam int MAX_NODES = 1024;
   localparam int EDGE_CAP  = MAX_NODES - 1;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int DEG_W     = NODE_W + 1;
   localparam int DIST_W    = 10;
   localparam int NCNT_W    = 11;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_code_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_EDGE_WR,
      OP_DEG_WA,
      OP_DEG_RB,
      OP_DEG_WB,
      OP_SWEEP_ALL,
      OP_SWEEP_DEG,
      OP_SWEEP_RUN,
      OP_SWEEP_VIS,
      OP_ROOT_INIT,
      OP_LEAF_INIT,
      OP_SCAN_RD,
      OP_SCAN_CHK,
      OP_POP_RD,
      OP_POP_DIST,
      OP_POP_DU,
      OP_E_RD,
      OP_E_CHK,
      OP_E_VIS,
      OP_Q_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      sel_leaf;
   } dp_cmd_type;

   typedef struct packed {
      cmd_code_type req_cmd;
      logic         edge_full;
      logic         sweep_last;
      logic         queue_empty;
      logic         edges_done;
      logic         scan_done;
      logic         rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/tree_root_leaf_distance_bfs.sv
// ----------------------------------------------------------------------------
// tree_root_leaf_distance_bfs
// per-node minimum of root depth and nearest-leaf distance over a loaded tree
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its stores before taking
// a request. An add-edge is dropped when the edge store is full, and a clear
// runs the degree-store clearing pass. A run holds off requests for its
// clearing passes and leaf scan and for both searches, in which every
// dequeued node scans the whole edge store through the single read port of
// the edge memories.
`timescale 1ns / 1ps
`default_nettype none

module tree_root_leaf_distance_bfs
   import trld_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [NODE_W-1:0]   req_first_node,
   input  wire logic [NODE_W-1:0]   req_second_node,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [DIST_W-1:0]   rsp_node_distance,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [NCNT_W-1:0]   csr_node_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   trld_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .status, .cmd);

   trld_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .req_cmd, .req_first_node, .req_second_node,
      .rsp_valid, .rsp_stall, .rsp_node_distance,
      .csr_valid, .csr_ready, .csr_node_count);

endmodule

`default_nettype wire

>>> sv/trld_ram.sv
// ----------------------------------------------------------------------------
// trld_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/trld_datapath.sv
// ----------------------------------------------------------------------------
// trld_datapath
// edge, degree, distance, visited and queue stores with their counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trld_datapath
   import trld_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [NODE_W-1:0]   req_first_node,
   input  wire logic [NODE_W-1:0]   req_second_node,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [DIST_W-1:0]   rsp_node_distance,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [NCNT_W-1:0]   csr_node_count
);

   logic [NODE_W-1:0] a_ff, b_ff, u_ff, du_ff, v_ff, v_in, eidx_ff, sweep_ff;
   logic [NODE_W-1:0] edge_total_ff;
   logic [CNT_W-1:0]  head_ff, tail_ff, scan_ff, limit;
   logic [NCNT_W-1:0] node_count_ff;
   logic              cand_ff, cand_in, visit_ok;
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] rsp_dist_ff, dist_min;

   logic              edge_we;
   logic [NODE_W-1:0] ea_rd, eb_rd;
   logic              deg_we;
   logic [NODE_W-1:0] deg_waddr, deg_raddr;
   logic [DEG_W-1:0]  deg_wdata, deg_rd;
   logic              vis_we, vis_wdata, vis_rd;
   logic [NODE_W-1:0] vis_waddr;
   logic              root_we, leaf_we;
   logic [NODE_W-1:0] dist_waddr, dist_raddr;
   logic [DIST_W-1:0] dist_wdata, root_rd, leaf_rd;
   logic              q_we;
   logic [NODE_W-1:0] q_waddr, q_wdata, q_rd;

   trld_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_edge_a (
      .clock, .wr_en(edge_we), .wr_addr(edge_total_ff), .wr_data(a_ff),
      .rd_addr(eidx_ff), .rd_data(ea_rd));
   trld_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_edge_b (
      .clock, .wr_en(edge_we), .wr_addr(edge_total_ff), .wr_data(b_ff),
      .rd_addr(eidx_ff), .rd_data(eb_rd));
   trld_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_degree (
      .clock, .wr_en(deg_we), .wr_addr(deg_waddr), .wr_data(deg_wdata),
      .rd_addr(deg_raddr), .rd_data(deg_rd));
   trld_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
      .clock, .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(v_in), .rd_data(vis_rd));
   trld_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_root_dist (
      .clock, .wr_en(root_we), .wr_addr(dist_waddr), .wr_data(dist_wdata),
      .rd_addr(dist_raddr), .rd_data(root_rd));
   trld_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_leaf_dist (
      .clock, .wr_en(leaf_we), .wr_addr(dist_waddr), .wr_data(dist_wdata),
      .rd_addr(dist_raddr), .rd_data(leaf_rd));
   trld_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(head_ff[NODE_W-1:0]), .rd_data(q_rd));

   // neighbor candidate of the popped node on the edge just read
   always_comb begin
      cand_in = (ea_rd == u_ff) || (eb_rd == u_ff);
      v_in    = (ea_rd == u_ff) ? eb_rd : ea_rd;
   end

   assign visit_ok = cand_ff && !vis_rd && (tail_ff < CNT_W'(MAX_NODES));
   assign dist_min = (root_rd < leaf_rd) ? root_rd : leaf_rd;
   assign limit    = (node_count_ff > NCNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(node_count_ff);

   always_comb begin
      edge_we    = 1'b0;
      deg_we     = 1'b0;
      deg_waddr  = a_ff;
      deg_wdata  = deg_rd + DEG_W'(1);
      deg_raddr  = a_ff;
      vis_we     = 1'b0;
      vis_waddr  = v_ff;
      vis_wdata  = 1'b1;
      root_we    = 1'b0;
      leaf_we    = 1'b0;
      dist_waddr = v_ff;
      dist_wdata = du_ff + DIST_W'(1);
      dist_raddr = a_ff;
      q_we       = 1'b0;
      q_waddr    = tail_ff[NODE_W-1:0];
      q_wdata    = v_ff;
      case (cmd.op) inside
         OP_EDGE_WR: begin
            edge_we = 1'b1;
         end
         OP_DEG_WA: begin
            deg_we = 1'b1;
         end
         OP_DEG_RB: begin
            deg_raddr = b_ff;
         end
         OP_DEG_WB: begin
            deg_we    = 1'b1;
            deg_waddr = b_ff;
         end
         OP_SWEEP_ALL, OP_SWEEP_DEG, OP_SWEEP_RUN, OP_SWEEP_VIS: begin
            deg_waddr  = sweep_ff;
            deg_wdata  = '0;
            vis_waddr  = sweep_ff;
            vis_wdata  = 1'b0;
            dist_waddr = sweep_ff;
            dist_wdata = '0;
            deg_we     = (cmd.op == OP_SWEEP_ALL) || (cmd.op == OP_SWEEP_DEG);
            vis_we     = (cmd.op != OP_SWEEP_DEG);
            root_we    = (cmd.op == OP_SWEEP_ALL) || (cmd.op == OP_SWEEP_RUN);
            leaf_we    = root_we;
         end
         OP_ROOT_INIT: begin
            vis_we    = 1'b1;
            vis_waddr = '0;
            q_we      = 1'b1;
            q_waddr   = '0;
            q_wdata   = '0;
         end
         OP_SCAN_RD: begin
            deg_raddr = scan_ff[NODE_W-1:0];
         end
         OP_SCAN_CHK: begin
            vis_waddr = scan_ff[NODE_W-1:0];
            q_wdata   = scan_ff[NODE_W-1:0];
            vis_we    = (deg_rd == DEG_W'(1));
            q_we      = (deg_rd == DEG_W'(1));
         end
         OP_POP_DIST: begin
            dist_raddr = q_rd;
         end
         OP_E_VIS: begin
            vis_we  = visit_ok;
            q_we    = visit_ok;
            root_we = visit_ok && !cmd.sel_leaf;
            leaf_we = visit_ok && cmd.sel_leaf;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         scan_ff       <= '0;
         sweep_ff      <= '0;
         eidx_ff       <= '0;
         cand_ff       <= 1'b0;
         node_count_ff <= NCNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            node_count_ff <= csr_node_count;
         end
         if (rsp_valid_ff && !rsp_stall && (cmd.op != OP_Q_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op) inside
            OP_LOAD: begin
               a_ff <= req_first_node;
               b_ff <= req_second_node;
            end
            OP_DEG_WB: begin
               edge_total_ff <= edge_total_ff + NODE_W'(1);
            end
            OP_SWEEP_ALL, OP_SWEEP_DEG, OP_SWEEP_RUN, OP_SWEEP_VIS: begin
               sweep_ff <= sweep_ff + NODE_W'(1);
               if (cmd.op == OP_SWEEP_DEG || cmd.op == OP_SWEEP_ALL) begin
                  edge_total_ff <= '0;
               end
            end
            OP_ROOT_INIT: begin
               head_ff <= '0;
               tail_ff <= CNT_W'(1);
            end
            OP_LEAF_INIT: begin
               head_ff <= '0;
               tail_ff <= '0;
               scan_ff <= '0;
            end
            OP_SCAN_CHK: begin
               scan_ff <= scan_ff + CNT_W'(1);
               if (deg_rd == DEG_W'(1)) begin
                  tail_ff <= tail_ff + CNT_W'(1);
               end
            end
            OP_POP_RD: begin
               head_ff <= head_ff + CNT_W'(1);
            end
            OP_POP_DIST: begin
               u_ff <= q_rd;
            end
            OP_POP_DU: begin
               du_ff   <= cmd.sel_leaf ? leaf_rd : root_rd;
               eidx_ff <= '0;
            end
            OP_E_CHK: begin
               cand_ff <= cand_in;
               v_ff    <= v_in;
               eidx_ff <= eidx_ff + NODE_W'(1);
            end
            OP_E_VIS: begin
               if (visit_ok) begin
                  tail_ff <= tail_ff + CNT_W'(1);
               end
            end
            OP_Q_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_dist_ff  <= dist_min;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status.req_cmd     = cmd_code_type'(req_cmd);
      status.edge_full   = (edge_total_ff == NODE_W'(EDGE_CAP));
      status.sweep_last  = (sweep_ff == NODE_W'(MAX_NODES - 1));
      status.queue_empty = (head_ff == tail_ff);
      status.edges_done  = (eidx_ff == edge_total_ff);
      status.scan_done   = (scan_ff >= limit);
      status.rsp_busy    = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_node_distance = rsp_dist_ff;
   assign csr_ready         = 1'b1;

endmodule

`default_nettype wire

>>> sv/trld_controller.sv
// ----------------------------------------------------------------------------
// trld_controller
// command sequencer for edge load, clear, query and the two searches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trld_controller
   import trld_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_ADD_EDGE,
      S_ADD_WA,
      S_ADD_RB,
      S_ADD_WB,
      S_CLEAR,
      S_RUN_CLR,
      S_ROOT_INIT,
      S_LEAF_CLR,
      S_LEAF_INIT,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_POP,
      S_POP_DIST,
      S_POP_DU,
      S_E_RD,
      S_E_CHK,
      S_E_VIS,
      S_Q_RD,
      S_Q_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      leaf_ff, leaf_in;

   always_comb begin
      state_in     = state_ff;
      leaf_in      = leaf_ff;
      cmd.op       = OP_NONE;
      cmd.sel_leaf = leaf_ff;
      unique case (state_ff)
         S_INIT: begin
            cmd.op = OP_SWEEP_ALL;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               unique case (status.req_cmd)
                  CMD_ADD:   state_in = status.edge_full ? S_IDLE : S_ADD_EDGE;
                  CMD_RUN:   state_in = S_RUN_CLR;
                  CMD_QUERY: state_in = S_Q_RD;
                  CMD_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_EDGE: begin
            cmd.op   = OP_EDGE_WR;
            state_in = S_ADD_WA;
         end
         S_ADD_WA: begin
            cmd.op   = OP_DEG_WA;
            state_in = S_ADD_RB;
         end
         S_ADD_RB: begin
            cmd.op   = OP_DEG_RB;
            state_in = S_ADD_WB;
         end
         S_ADD_WB: begin
            cmd.op   = OP_DEG_WB;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.op = OP_SWEEP_DEG;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_RUN_CLR: begin
            cmd.op = OP_SWEEP_RUN;
            if (status.sweep_last) state_in = S_ROOT_INIT;
         end
         S_ROOT_INIT: begin
            cmd.op   = OP_ROOT_INIT;
            leaf_in  = 1'b0;
            state_in = S_POP;
         end
         S_LEAF_CLR: begin
            cmd.op = OP_SWEEP_VIS;
            if (status.sweep_last) state_in = S_LEAF_INIT;
         end
         S_LEAF_INIT: begin
            cmd.op   = OP_LEAF_INIT;
            leaf_in  = 1'b1;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            if (status.scan_done) begin
               state_in = S_POP;
            end else begin
               cmd.op   = OP_SCAN_RD;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            cmd.op   = OP_SCAN_CHK;
            state_in = S_SCAN_RD;
         end
         S_POP: begin
            if (status.queue_empty) begin
               state_in = leaf_ff ? S_IDLE : S_LEAF_CLR;
            end else begin
               cmd.op   = OP_POP_RD;
               state_in = S_POP_DIST;
            end
         end
         S_POP_DIST: begin
            cmd.op   = OP_POP_DIST;
            state_in = S_POP_DU;
         end
         S_POP_DU: begin
            cmd.op   = OP_POP_DU;
            state_in = S_E_RD;
         end
         S_E_RD: begin
            if (status.edges_done) begin
               state_in = S_POP;
            end else begin
               cmd.op   = OP_E_RD;
               state_in = S_E_CHK;
            end
         end
         S_E_CHK: begin
            cmd.op   = OP_E_CHK;
            state_in = S_E_VIS;
         end
         S_E_VIS: begin
            cmd.op   = OP_E_VIS;
            state_in = S_E_RD;
         end
         S_Q_RD: begin
            state_in = S_Q_OUT;
         end
         S_Q_OUT: begin
            if (!status.rsp_busy) begin
               cmd.op   = OP_Q_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         leaf_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         leaf_ff  <= leaf_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> sv/trld_checker.sv
// ----------------------------------------------------------------------------
// trld_checker
// port-level checks bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trld_checker
   import trld_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [1:0]        req_cmd,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [DIST_W-1:0] rsp_node_distance,
   input wire logic              csr_ready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_node_distance))
      else $error("stalled result changed");

   a_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request taken during clearing pass");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_QUERY) |=> req_stall)
      else $error("query did not hold off next request");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without query in progress");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready");

endmodule

bind tree_root_leaf_distance_bfs trld_checker u_trld_checker (
   .clock, .reset, .req_valid, .req_stall, .req_cmd,
   .rsp_valid, .rsp_stall, .rsp_node_distance, .csr_ready);

`default_nettype wire

>>> test/tree_root_leaf_distance_bfs_checker.sv
// ----------------------------------------------------------------------------
// tree_root_leaf_distance_bfs_checker
// watches request, response and csr transfers, keeps a behavioral copy of the
// edge store and both search results, and compares every returned distance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_root_leaf_distance_bfs_checker
   import trld_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [NODE_W-1:0]   req_first_node,
   input  logic [NODE_W-1:0]   req_second_node,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [DIST_W-1:0]   rsp_node_distance,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [NCNT_W-1:0]   csr_node_count,
   output int                  error_count,
   output int                  pending_count
);

   logic [NCNT_W-1:0] tree_size;
   logic [NODE_W-1:0] end_a [EDGE_CAP];
   logic [NODE_W-1:0] end_b [EDGE_CAP];
   int                stored_edges;
   int                degree [MAX_NODES];
   logic [DIST_W-1:0] depth [MAX_NODES];
   logic [DIST_W-1:0] leaf_gap [MAX_NODES];
   logic [DIST_W-1:0] distance_fifo [$];

   // hop counts from the nodes already queued, over the stored edges
   function automatic void spread(bit use_leaf, int frontier [$]);
      bit seen [MAX_NODES];
      int u;
      int v;
      logic [DIST_W-1:0] du;
      foreach (seen[i]) seen[i] = 0;
      foreach (frontier[i]) seen[frontier[i]] = 1;
      while (frontier.size() > 0) begin
         u = frontier.pop_front();
         du = use_leaf ? leaf_gap[u] : depth[u];
         for (int e = 0; e < stored_edges; e++) begin
            v = -1;
            if (end_a[e] == u) v = end_b[e];
            else if (end_b[e] == u) v = end_a[e];
            if (v >= 0 && !seen[v]) begin
               seen[v] = 1;
               if (use_leaf) leaf_gap[v] = du + DIST_W'(1);
               else depth[v] = du + DIST_W'(1);
               frontier.insert(frontier.size(), v);
            end
         end
      end
   endfunction

   function automatic void run_searches();
      int start [$];
      int lim;
      foreach (depth[i]) begin
         depth[i] = '0;
         leaf_gap[i] = '0;
      end
      start.insert(0, 0);
      spread(0, start);
      start.delete();
      lim = (tree_size < MAX_NODES) ? int'(tree_size) : MAX_NODES;
      for (int i = 0; i < lim; i++)
         if (degree[i] == 1) start.insert(start.size(), i);
      spread(1, start);
   endfunction

   always @(posedge clock) begin
      logic [DIST_W-1:0] want;
      if (reset) begin
         tree_size = NCNT_W'(1);
         stored_edges = 0;
         foreach (degree[i]) begin
            degree[i] = 0;
            depth[i] = '0;
            leaf_gap[i] = '0;
         end
         distance_fifo.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (distance_fifo.size() == 0) begin
               $error("node_distance: unexpected transfer, actual %0d", rsp_node_distance);
               error_count++;
            end else begin
               want = distance_fifo.pop_front();
               if (rsp_node_distance !== want) begin
                  $error("node_distance: expected %0d actual %0d", want, rsp_node_distance);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) tree_size = csr_node_count;
         if (req_valid && !req_stall) begin
            case (cmd_code_type'(req_cmd))
               CMD_ADD: begin
                  if (stored_edges < EDGE_CAP) begin
                     end_a[stored_edges] = req_first_node;
                     end_b[stored_edges] = req_second_node;
                     stored_edges++;
                     degree[req_first_node]++;
                     degree[req_second_node]++;
                  end
               end
               CMD_RUN: run_searches();
               CMD_QUERY: begin
                  want = (depth[req_first_node] < leaf_gap[req_first_node]) ?
                         depth[req_first_node] : leaf_gap[req_first_node];
                  distance_fifo.insert(distance_fifo.size(), want);
               end
               CMD_CLEAR: begin
                  stored_edges = 0;
                  foreach (degree[i]) degree[i] = 0;
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = distance_fifo.size();
   end

   initial begin
      error_count = 0;
      pending_count = 0;
   end

endmodule

>>> test/tree_root_leaf_distance_bfs_tb.sv
// ----------------------------------------------------------------------------
// tree_root_leaf_distance_bfs_tb
// loads random trees with relabeled nodes, runs both searches under several
// node counts and queries nodes with random idle gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_root_leaf_distance_bfs_tb
   import trld_pkg::*;
();

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_cmd;
   logic [NODE_W-1:0]   req_first_node;
   logic [NODE_W-1:0]   req_second_node;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [DIST_W-1:0]   rsp_node_distance;
   logic                csr_valid;
   logic                csr_ready;
   logic [NCNT_W-1:0]   csr_node_count;
   int                  error_count;
   int                  pending_count;
   bit                  quiet;
   int                  responses_seen;

   tree_root_leaf_distance_bfs dut (.*);
   tree_root_leaf_distance_bfs_checker checker_inst (.*);

   initial clock = 0;
   always #5 clock = ~clock;

   task automatic send(cmd_code_type cmd, int a, int b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_cmd = cmd;
      req_first_node = NODE_W'(a);
      req_second_node = NODE_W'(b);
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // a query after a run or clear only transfers once the block is done
   task automatic settle();
      send(CMD_QUERY, $urandom_range(0, MAX_NODES - 1), $urandom);
      req_valid = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_size(int value);
      settle();
      csr_valid = 1;
      csr_node_count = NCNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic load_tree(int n);
      int  label [];
      bit  taken [MAX_NODES];
      int  p;
      int  cand;
      label = new[n];
      foreach (taken[i]) taken[i] = 0;
      label[0] = 0;
      taken[0] = 1;
      for (int i = 1; i < n; i++) begin
         do cand = $urandom_range(1, MAX_NODES - 1); while (taken[cand]);
         taken[cand] = 1;
         label[i] = cand;
      end
      for (int i = 1; i < n; i++) begin
         p = $urandom_range(0, i - 1);
         if ($urandom_range(0, 1)) send(CMD_ADD, label[i], label[p]);
         else send(CMD_ADD, label[p], label[i]);
      end
      if ($urandom_range(0, 4) == 0)
         send(CMD_ADD, label[$urandom_range(0, n - 1)], label[$urandom_range(0, n - 1)]);
      send(CMD_RUN, $urandom, $urandom);
      repeat ($urandom_range(8, 20)) begin
         if ($urandom_range(0, 5) == 0) send(CMD_QUERY, $urandom, $urandom);
         else send(CMD_QUERY, label[$urandom_range(0, n - 1)], $urandom);
      end
   endtask

   // receiver side: per-result stall draw plus one long hold-off
   initial begin
      int n;
      rsp_stall = 1;
      responses_seen = 0;
      @(negedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 3);
         rsp_stall = 1;
         repeat (n) @(negedge clock);
         if (responses_seen == 40) repeat (400) @(negedge clock);
         rsp_stall = 0;
         do @(posedge clock); while (!rsp_valid);
         responses_seen++;
         @(negedge clock);
      end
   end

   initial begin
      int sizes [6] = '{1, 1024, 0, 2047, 3, 600};
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_ADD;
      req_first_node = '0;
      req_second_node = '0;
      csr_valid = 0;
      csr_node_count = '0;
      quiet = 0;
      repeat (7) @(negedge clock);
      reset = 0;

      // queries before any run read zero
      send(CMD_QUERY, 0, 0);
      send(CMD_QUERY, MAX_NODES - 1, MAX_NODES - 1);
      write_size(MAX_NODES);
      send(CMD_ADD, 0, MAX_NODES - 1);
      send(CMD_ADD, MAX_NODES - 1, 5);
      send(CMD_ADD, 5, 5);
      send(CMD_ADD, 5, 6);
      send(CMD_ADD, 5, 6);
      send(CMD_ADD, 7, 8);
      send(CMD_RUN, 0, 0);
      for (int i = 0; i < 9; i++) send(CMD_QUERY, (i == 8) ? MAX_NODES - 1 : i, 0);
      send(CMD_CLEAR, 0, 0);
      send(CMD_QUERY, 5, 0);
      send(CMD_RUN, 0, 0);
      send(CMD_QUERY, 5, 0);

      // edge store full: the last add is dropped
      send(CMD_CLEAR, 0, 0);
      send(CMD_ADD, 0, 1);
      repeat (EDGE_CAP - 1) send(CMD_ADD, 2, 2);
      send(CMD_ADD, 1, 3);
      send(CMD_RUN, 0, 0);
      for (int i = 0; i < 4; i++) send(CMD_QUERY, i, 0);
      send(CMD_CLEAR, 0, 0);

      for (int phase = 0; phase < 8; phase++) begin
         quiet = (phase % 4 == 3);
         if (phase < 6) write_size(sizes[phase]);
         else if (phase % 2 == 0) write_size($urandom_range(1, MAX_NODES));
         load_tree(($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(1, 16));
         send(CMD_CLEAR, $urandom, $urandom);
      end
      quiet = 0;
      req_valid = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) $display("tree_root_leaf_distance_bfs_tb: clean");
      else $display("tree_root_leaf_distance_bfs_tb: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("tree_root_leaf_distance_bfs_tb: errors");
      $finish;
   end

endmodule
